// ===== src/dmt_pkg.sv =====
// shared constants for the detection merge table
// field widths, register indexes and reset values; no dependencies
package dmt_pkg;

  localparam int RADIUS_W = 15;
  localparam int THR_W    = 16;
  localparam int HITS_W   = 16;
  localparam int COLOR_W  = 8;
  localparam int INDEX_W  = 4;
  localparam int CFG_W    = 16;
  localparam int CFG_IW   = 1;

  localparam logic [CFG_IW-1:0] REG_MATCH_RADIUS     = 1'b0;
  localparam logic [CFG_IW-1:0] REG_REPORT_THRESHOLD = 1'b1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd512;
  localparam logic [THR_W-1:0]    THR_RESET    = 16'd2;
  localparam logic [HITS_W-1:0]   HITS_MAX     = 16'hFFFF;
  localparam logic [HITS_W-1:0]   HITS_ONE     = 16'd1;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [HITS_W-1:0]  hits_t;

endpackage

// ===== src/dmt_if.sv =====
// valid/ready channels for detections and results
// depends on dmt_pkg
interface dmt_det_if import dmt_pkg::*; #(parameter int CW = 16);
  logic           valid;
  logic           ready;
  logic signed [CW-1:0] det_x;
  logic signed [CW-1:0] det_y;
  logic signed [CW-1:0] det_z;
  color_t         det_red;
  color_t         det_green;
  color_t         det_blue;
  modport source (output valid, det_x, det_y, det_z, det_red, det_green, det_blue,
                  input ready);
  modport sink   (input valid, det_x, det_y, det_z, det_red, det_green, det_blue,
                  output ready);
endinterface

interface dmt_res_if import dmt_pkg::*; #(parameter int CW = 16);
  logic           valid;
  logic           ready;
  logic           report_valid;
  logic [INDEX_W-1:0] entry_index;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;
  color_t         red;
  color_t         green;
  color_t         blue;
  hits_t          hits;
  logic           table_full;
  logic           last;
  modport source (output valid, report_valid, entry_index, pos_x, pos_y, pos_z, red, green,
                  blue, hits, table_full, last, input ready);
  modport sink   (input valid, report_valid, entry_index, pos_x, pos_y, pos_z, red, green,
                  blue, hits, table_full, last, output ready);
endinterface

// ===== src/detection_merge_table_core.sv =====
// detection merge table: entry memory, match pass with shared divider lanes, report scan
// depends on dmt_pkg and dmt_if
//
// Each detection is checked against every used entry in slot order: one memory read, a
// squared distance test, and for a match a running mean of six channels computed by six
// restoring divider lanes, one quotient bit per cycle, then written back. After the pass
// a new entry may be appended, then the entries at or above the report threshold are
// read and sent out one at a time, each waiting for the output register to be free, with
// skipped slots stepped over; if none qualify, a single result with no report is sent.
// A new detection is taken once the previous one has handed its last result to the
// output register.
module detection_merge_table_core import dmt_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int COORD_WIDTH   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  dmt_det_if.sink           in_det,
  dmt_res_if.source         out_res,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int N   = TABLE_ENTRIES;
  localparam int IW  = (N > 1) ? $clog2(N) : 1;
  localparam int UW  = $clog2(N + 1);
  localparam int EW  = 3 * CW + 3 * COLOR_W + HITS_W;
  localparam int MW  = CW + 17;
  localparam int PW  = CW + 19;
  localparam int CNW = $clog2(MW + 1);
  localparam int XW  = CW + 16;
  localparam int NL  = 6;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_WB    = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_RWAIT = 4'd8;

  logic [3:0] state_r, state_nxt;

  logic [RADIUS_W-1:0] rad_r;
  logic [THR_W-1:0]    thr_r;

  logic [EW-1:0] mem [N];
  logic [EW-1:0] mem_q;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata;

  logic [UW-1:0] used_r;
  logic [UW-1:0] idx_r;
  logic [N-1:0]  qual_r;
  logic          matched_r;
  logic          full_r;

  logic signed [CW-1:0] dx_r, dy_r, dz_r;
  color_t               dr_r, dg_r, db_r;

  logic [2*RADIUS_W-1:0] sqx_r, sqy_r, sqz_r, rad2_r;
  logic                  near_r;

  logic signed [CW+17:0] prod_r [NL];
  logic [MW-1:0]         q_r    [NL];
  logic [16:0]           rem_r  [NL];
  logic                  neg_r  [NL];
  logic [16:0]           dvs_r;
  logic [CNW-1:0]        cnt_r;

  logic                  out_valid_r;
  logic                  out_rv_r, out_full_r, out_last_r;
  logic [INDEX_W-1:0]    out_idx_r;
  logic signed [CW-1:0]  out_x_r, out_y_r, out_z_r;
  color_t                out_r_r, out_g_r, out_b_r;
  hits_t                 out_h_r;

  // entry word fields
  logic signed [CW-1:0] ex, ey, ez;
  color_t               er, eg, eb;
  hits_t                eh, eh_inc;
  assign ex = mem_q[EW-1 -: CW];
  assign ey = mem_q[EW-1-CW -: CW];
  assign ez = mem_q[EW-1-2*CW -: CW];
  assign er = mem_q[HITS_W+3*COLOR_W-1 -: COLOR_W];
  assign eg = mem_q[HITS_W+2*COLOR_W-1 -: COLOR_W];
  assign eb = mem_q[HITS_W+COLOR_W-1 -: COLOR_W];
  assign eh = mem_q[HITS_W-1:0];
  assign eh_inc = (eh == HITS_MAX) ? HITS_MAX : eh + HITS_ONE;

  logic signed [CW:0] old_l [NL];
  logic signed [CW:0] new_l [NL];
  always_comb begin
    old_l[0] = (CW+1)'(ex);
    old_l[1] = (CW+1)'(ey);
    old_l[2] = (CW+1)'(ez);
    old_l[3] = $signed({{(CW+1-COLOR_W){1'b0}}, er});
    old_l[4] = $signed({{(CW+1-COLOR_W){1'b0}}, eg});
    old_l[5] = $signed({{(CW+1-COLOR_W){1'b0}}, eb});
    new_l[0] = (CW+1)'(dx_r);
    new_l[1] = (CW+1)'(dy_r);
    new_l[2] = (CW+1)'(dz_r);
    new_l[3] = $signed({{(CW+1-COLOR_W){1'b0}}, dr_r});
    new_l[4] = $signed({{(CW+1-COLOR_W){1'b0}}, dg_r});
    new_l[5] = $signed({{(CW+1-COLOR_W){1'b0}}, db_r});
  end

  // distance terms
  logic signed [CW+1:0] sx, sy, sz;
  logic [CW:0]          ax, ay, az;
  logic [XW-1:0]        radx;
  always_comb begin
    sx = (CW+2)'(ex) - (CW+2)'(dx_r);
    sy = (CW+2)'(ey) - (CW+2)'(dy_r);
    sz = (CW+2)'(ez) - (CW+2)'(dz_r);
    ax = sx[CW+1] ? (CW+1)'(-sx) : sx[CW:0];
    ay = sy[CW+1] ? (CW+1)'(-sy) : sy[CW:0];
    az = sz[CW+1] ? (CW+1)'(-sz) : sz[CW:0];
    radx = XW'(rad_r);
  end

  logic [2*RADIUS_W+1:0] dist2;
  logic                  match;
  assign dist2 = (2*RADIUS_W+2)'(sqx_r) + (2*RADIUS_W+2)'(sqy_r) + (2*RADIUS_W+2)'(sqz_r);
  assign match = near_r && (dist2 < (2*RADIUS_W+2)'(rad2_r));

  // mean results
  logic [CW-1:0] mean_l [NL];
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      mean_l[l] = neg_r[l] ? CW'(-q_r[l][CW-1:0]) : q_r[l][CW-1:0];
    end
  end

  logic [UW:0] idx_inc;
  logic        more;
  logic [N-1:0] qual_hi;
  assign idx_inc = (UW+1)'(idx_r) + (UW+1)'(1);
  assign more    = idx_inc < (UW+1)'(used_r);
  assign qual_hi = (qual_r >> idx_r[IW-1:0]) >> 1;

  assign in_det.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx_r[IW-1:0];
    mem_raddr = idx_r[IW-1:0];
    mem_wdata = {mean_l[0], mean_l[1], mean_l[2], mean_l[3][COLOR_W-1:0],
                 mean_l[4][COLOR_W-1:0], mean_l[5][COLOR_W-1:0], eh_inc};
    unique case (state_r)
      S_IDLE: begin
        if (in_det.valid) begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_nxt = (used_r == '0) ? S_FIN : S_SQ;
        end
      end
      S_SQ:  state_nxt = S_CMP;
      S_CMP: begin
        if (match) begin
          state_nxt = S_MUL;
        end else if (more) begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[IW-1:0];
          state_nxt = S_SQ;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MUL: state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == CNW'(MW - 1)) state_nxt = S_WB;
      end
      S_WB: begin
        mem_we = 1'b1;
        if (more) begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[IW-1:0];
          state_nxt = S_SQ;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r) begin
          if (!matched_r && used_r != UW'(N)) begin
            mem_we    = 1'b1;
            mem_waddr = used_r[IW-1:0];
            mem_wdata = {dx_r, dy_r, dz_r, dr_r, dg_r, db_r, HITS_ONE};
          end
          state_nxt = (qual_r == '0) ? S_IDLE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (qual_r[idx_r[IW-1:0]] && !out_valid_r) begin
          mem_re    = 1'b1;
          state_nxt = S_RWAIT;
        end
      end
      S_RWAIT: state_nxt = (qual_hi == '0) ? S_IDLE : S_SCAN;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rad_r       <= RADIUS_RESET;
      thr_r       <= THR_RESET;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MATCH_RADIUS:     rad_r <= cfg_data[RADIUS_W-1:0];
          REG_REPORT_THRESHOLD: thr_r <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (out_res.valid && out_res.ready) out_valid_r <= 1'b0;
      if (state_r == S_FIN && !out_valid_r) begin
        if (!matched_r && used_r != UW'(N)) used_r <= used_r + UW'(1);
        if (qual_r == '0) out_valid_r <= 1'b1;
      end
      if (state_r == S_RWAIT) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_det.valid) begin
          dx_r      <= in_det.det_x;
          dy_r      <= in_det.det_y;
          dz_r      <= in_det.det_z;
          dr_r      <= in_det.det_red;
          dg_r      <= in_det.det_green;
          db_r      <= in_det.det_blue;
          idx_r     <= '0;
          qual_r    <= '0;
          matched_r <= 1'b0;
        end
      end
      S_SQ: begin
        near_r <= (XW'(ax) < radx) && (XW'(ay) < radx) && (XW'(az) < radx);
        sqx_r  <= RADIUS_W'(ax) * RADIUS_W'(ax);
        sqy_r  <= RADIUS_W'(ay) * RADIUS_W'(ay);
        sqz_r  <= RADIUS_W'(az) * RADIUS_W'(az);
        rad2_r <= rad_r * rad_r;
      end
      S_CMP: begin
        if (match) begin
          matched_r <= 1'b1;
          for (int l = 0; l < NL; l++) begin
            prod_r[l] <= old_l[l] * $signed({1'b0, eh});
          end
        end else begin
          qual_r[idx_r[IW-1:0]] <= (eh >= thr_r);
          if (more) idx_r <= idx_inc[UW-1:0];
        end
      end
      S_MUL: begin
        for (int l = 0; l < NL; l++) begin
          logic signed [PW-1:0] num;
          num      = PW'(prod_r[l]) + PW'(new_l[l]);
          neg_r[l] <= num[PW-1];
          q_r[l]   <= num[PW-1] ? MW'(-num) : num[MW-1:0];
          rem_r[l] <= '0;
        end
        dvs_r <= 17'(eh) + 17'd1;
        cnt_r <= '0;
      end
      S_DIV: begin
        for (int l = 0; l < NL; l++) begin
          logic [17:0] t;
          t = {rem_r[l], q_r[l][MW-1]};
          if (t >= {1'b0, dvs_r}) begin
            rem_r[l] <= 17'(t - {1'b0, dvs_r});
            q_r[l]   <= {q_r[l][MW-2:0], 1'b1};
          end else begin
            rem_r[l] <= t[16:0];
            q_r[l]   <= {q_r[l][MW-2:0], 1'b0};
          end
        end
        cnt_r <= cnt_r + CNW'(1);
      end
      S_WB: begin
        qual_r[idx_r[IW-1:0]] <= (eh_inc >= thr_r);
        if (more) idx_r <= idx_inc[UW-1:0];
      end
      S_FIN: begin
        if (!out_valid_r) begin
          full_r     <= !matched_r && used_r == UW'(N);
          idx_r      <= '0;
          out_rv_r   <= 1'b0;
          out_idx_r  <= '0;
          out_x_r    <= '0;
          out_y_r    <= '0;
          out_z_r    <= '0;
          out_r_r    <= '0;
          out_g_r    <= '0;
          out_b_r    <= '0;
          out_h_r    <= '0;
          out_full_r <= !matched_r && used_r == UW'(N);
          out_last_r <= 1'b1;
        end
      end
      S_SCAN: begin
        if (!qual_r[idx_r[IW-1:0]]) idx_r <= idx_inc[UW-1:0];
      end
      S_RWAIT: begin
        out_rv_r   <= 1'b1;
        out_idx_r  <= INDEX_W'(idx_r);
        out_x_r    <= ex;
        out_y_r    <= ey;
        out_z_r    <= ez;
        out_r_r    <= er;
        out_g_r    <= eg;
        out_b_r    <= eb;
        out_h_r    <= eh;
        out_full_r <= full_r;
        out_last_r <= (qual_hi == '0);
        idx_r      <= idx_inc[UW-1:0];
      end
      default: ;
    endcase
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.report_valid = out_rv_r;
  assign out_res.entry_index  = out_idx_r;
  assign out_res.pos_x        = out_x_r;
  assign out_res.pos_y        = out_y_r;
  assign out_res.pos_z        = out_z_r;
  assign out_res.red          = out_r_r;
  assign out_res.green        = out_g_r;
  assign out_res.blue         = out_b_r;
  assign out_res.hits         = out_h_r;
  assign out_res.table_full   = out_full_r;
  assign out_res.last         = out_last_r;

endmodule

// ===== tb/tb_top.sv =====
// testbench for detection_merge_table_core: directed table, then random detections
// checked field by field against an in-bench prediction; depends on dmt_pkg and dmt_if
module tb_top;
  import dmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int CW    = 16;

  typedef struct packed {
    logic signed [CW-1:0] x, y, z;
    color_t r, g, b;
  } det_t;

  typedef struct packed {
    logic               report_valid;
    logic [INDEX_W-1:0] entry_index;
    logic signed [CW-1:0] pos_x, pos_y, pos_z;
    color_t red, green, blue;
    hits_t  hits;
    logic   table_full;
    logic   last;
  } report_t;

  typedef enum logic {ROW_DET, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [CFG_IW-1:0] idx;
    logic [CFG_W-1:0]  data;
    det_t det;
    bit   typed;
    bit   typed_full;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  dmt_det_if #(.CW(CW)) det_ch();
  dmt_res_if #(.CW(CW)) res_ch();

  detection_merge_table_core #(.TABLE_ENTRIES(NSLOT), .COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst_n(rst_n), .in_det(det_ch), .out_res(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted table
  longint slot_x[NSLOT], slot_y[NSLOT], slot_z[NSLOT];
  int     slot_r[NSLOT], slot_g[NSLOT], slot_b[NSLOT];
  int     slot_hits[NSLOT];
  int     slots_used;
  int     radius;
  int     threshold;

  report_t pending_reports[$];
  int  errors;
  bit  quiet;
  bit  hold_req;
  int  hold_cnt;
  int  sink_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic merge_detection(input det_t d, output report_t rq[$]);
    longint x, y, z, dx, dy, dz, r2;
    int n;
    bit matched;
    report_t o;
    x = d.x; y = d.y; z = d.z;
    matched = 0;
    rq = {};
    r2 = longint'(radius) * radius;
    for (int i = 0; i < slots_used; i++) begin
      dx = slot_x[i] - x; if (dx < 0) dx = -dx;
      dy = slot_y[i] - y; if (dy < 0) dy = -dy;
      dz = slot_z[i] - z; if (dz < 0) dz = -dz;
      if (dx < radius && dy < radius && dz < radius && dx*dx + dy*dy + dz*dz < r2) begin
        n = slot_hits[i];
        matched = 1;
        slot_x[i] = (slot_x[i] * n + x) / (n + 1);
        slot_y[i] = (slot_y[i] * n + y) / (n + 1);
        slot_z[i] = (slot_z[i] * n + z) / (n + 1);
        slot_r[i] = int'((longint'(slot_r[i]) * n + d.r) / (n + 1));
        slot_g[i] = int'((longint'(slot_g[i]) * n + d.g) / (n + 1));
        slot_b[i] = int'((longint'(slot_b[i]) * n + d.b) / (n + 1));
        slot_hits[i] = (n >= HITS_MAX) ? int'(HITS_MAX) : n + 1;
      end
    end
    for (int i = 0; i < slots_used; i++) begin
      if (slot_hits[i] >= threshold) begin
        o = '0;
        o.report_valid = 1'b1;
        o.entry_index = INDEX_W'(i);
        o.pos_x = CW'(slot_x[i]); o.pos_y = CW'(slot_y[i]); o.pos_z = CW'(slot_z[i]);
        o.red = COLOR_W'(slot_r[i]); o.green = COLOR_W'(slot_g[i]);
        o.blue = COLOR_W'(slot_b[i]);
        o.hits = HITS_W'(slot_hits[i]);
        rq = {rq, o};
      end
    end
    o = '0;
    if (!matched) begin
      if (slots_used < NSLOT) begin
        slot_x[slots_used] = x; slot_y[slots_used] = y; slot_z[slots_used] = z;
        slot_r[slots_used] = int'(d.r); slot_g[slots_used] = int'(d.g);
        slot_b[slots_used] = int'(d.b);
        slot_hits[slots_used] = 1;
        slots_used++;
      end else begin
        o.table_full = 1'b1;
      end
    end
    if (rq.size() == 0) rq = {rq, o};
    foreach (rq[i]) begin
      rq[i].table_full = o.table_full;
      rq[i].last = (i == rq.size() - 1);
    end
  endtask

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // sink side: random stalls and one long hold-off
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) begin
        res_ch.ready <= 1'b0;
        hold_cnt--;
      end else if (hold_req) begin
        hold_req = 0;
        hold_cnt = 400;
        res_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        res_ch.ready <= 1'b0;
        sink_gap--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(0, 13);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // result checking, sampled mid-cycle
  initial begin
    report_t e;
    forever begin
      @(negedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        if (pending_reports.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          e = pending_reports.pop_front();
          check_field("report_valid", e.report_valid, res_ch.report_valid);
          check_field("entry_index", e.entry_index, res_ch.entry_index);
          check_field("pos_x", e.pos_x, res_ch.pos_x);
          check_field("pos_y", e.pos_y, res_ch.pos_y);
          check_field("pos_z", e.pos_z, res_ch.pos_z);
          check_field("red", e.red, res_ch.red);
          check_field("green", e.green, res_ch.green);
          check_field("blue", e.blue, res_ch.blue);
          check_field("hits", e.hits, res_ch.hits);
          check_field("table_full", e.table_full, res_ch.table_full);
          check_field("last", e.last, res_ch.last);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_MATCH_RADIUS) radius = int'(val[RADIUS_W-1:0]);
    else threshold = int'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_det(input det_t d, input bit typed, input bit typed_full);
    report_t rq[$];
    report_t o;
    det_ch.valid <= 1'b1;
    det_ch.det_x <= d.x; det_ch.det_y <= d.y; det_ch.det_z <= d.z;
    det_ch.det_red <= d.r; det_ch.det_green <= d.g; det_ch.det_blue <= d.b;
    forever begin
      @(negedge clk);
      if (det_ch.ready) break;
    end
    @(posedge clk);
    merge_detection(d, rq);
    if (typed) begin
      o = '0;
      o.table_full = typed_full;
      o.last = 1'b1;
      pending_reports = {pending_reports, o};
    end else begin
      pending_reports = {pending_reports, rq};
    end
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 14);
      det_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [CW-1:0] clamp_coord(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return CW'(v);
  endfunction

  function automatic det_t random_det();
    det_t d;
    int pick, s, span;
    longint off;
    d.r = COLOR_W'($urandom); d.g = COLOR_W'($urandom); d.b = COLOR_W'($urandom);
    pick = $urandom_range(0, 99);
    s = $urandom_range(0, slots_used - 1);
    if (pick < 70 && slots_used > 0) begin
      span = (radius / 2 > 1) ? radius / 2 : 1;
      off = $urandom_range(0, 2 * span); d.x = clamp_coord(slot_x[s] + off - span);
      off = $urandom_range(0, 2 * span); d.y = clamp_coord(slot_y[s] + off - span);
      off = $urandom_range(0, 2 * span); d.z = clamp_coord(slot_z[s] + off - span);
    end else if (pick < 85 || slots_used == 0) begin
      d.x = CW'($urandom); d.y = CW'($urandom); d.z = CW'($urandom);
    end else begin
      // on or just inside the radius along one axis
      off = radius - $urandom_range(0, 1);
      if ($urandom_range(0, 1)) off = -off;
      d.x = clamp_coord(slot_x[s] + off);
      d.y = CW'(slot_y[s]);
      d.z = CW'(slot_z[s]);
    end
    return d;
  endfunction

  function automatic row_t det_row(int x, int y, int z, int r, int g, int b,
                                   bit typed, bit full);
    row_t w;
    w.kind = ROW_DET; w.idx = '0; w.data = '0;
    w.det.x = CW'(x); w.det.y = CW'(y); w.det.z = CW'(z);
    w.det.r = COLOR_W'(r); w.det.g = COLOR_W'(g); w.det.b = COLOR_W'(b);
    w.typed = typed; w.typed_full = full;
    return w;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IW-1:0] idx, int val);
    row_t w;
    w = det_row(0, 0, 0, 0, 0, 0, 0, 0);
    w.kind = ROW_CFG; w.idx = idx; w.data = CFG_W'(val);
    return w;
  endfunction

  initial begin
    row_t rows[$];
    int phase_radius[4];
    int phase_thr[4];
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    det_ch.valid = 1'b0;
    det_ch.det_x = '0; det_ch.det_y = '0; det_ch.det_z = '0;
    det_ch.det_red = '0; det_ch.det_green = '0; det_ch.det_blue = '0;
    errors = 0; quiet = 0; hold_req = 0; hold_cnt = 0; sink_gap = 0;
    slots_used = 0;
    radius = int'(RADIUS_RESET);
    threshold = int'(THR_RESET);
    foreach (slot_hits[i]) begin
      slot_x[i] = 0; slot_y[i] = 0; slot_z[i] = 0;
      slot_r[i] = 0; slot_g[i] = 0; slot_b[i] = 0; slot_hits[i] = 0;
    end

    // first row after reset, then a match, corners, wide radius, threshold zero,
    // radius zero, filling the table, and a dropped detection
    rows = {rows, det_row(0, 0, 0, 0, 0, 0, 1, 0)};
    rows = {rows, det_row(100, 0, 0, 255, 255, 255, 0, 0)};
    rows = {rows, det_row(-32768, -32768, -32768, 0, 0, 0, 0, 0)};
    rows = {rows, det_row(32767, 32767, 32767, 255, 255, 255, 0, 0)};
    rows = {rows, det_row(-32768, 32767, -32768, 170, 85, 1, 0, 0)};
    rows = {rows, cfg_row(REG_MATCH_RADIUS, 32767)};
    rows = {rows, det_row(0, 0, 0, 128, 64, 32, 0, 0)};
    rows = {rows, cfg_row(REG_REPORT_THRESHOLD, 0)};
    rows = {rows, det_row(0, 0, 0, 7, 200, 99, 0, 0)};
    rows = {rows, cfg_row(REG_MATCH_RADIUS, 0)};
    rows = {rows, det_row(50, 0, 0, 1, 2, 3, 0, 0)};
    rows = {rows, cfg_row(REG_REPORT_THRESHOLD, 65535)};
    for (int k = 0; k < 11; k++)
      rows = {rows, det_row(k * 5000 - 27000, 3000 - k * 4100, k * 777, k * 23, 255 - k, k,
                            1, 0)};
    rows = {rows, det_row(1234, -4321, 999, 9, 9, 9, 1, 1)};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        det_ch.valid <= 1'b0;
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        sender_gap();
        send_det(rows[i].det, rows[i].typed, rows[i].typed_full);
      end
    end

    phase_radius = '{512, 32767, 0, 0};
    phase_thr = '{2, 0, 65535, 0};
    phase_radius[3] = $urandom_range(1, 4000);
    phase_thr[3] = $urandom_range(1, 5);
    for (int p = 0; p < 4; p++) begin
      det_ch.valid <= 1'b0;
      write_reg(REG_MATCH_RADIUS, CFG_W'(phase_radius[p]));
      write_reg(REG_REPORT_THRESHOLD, CFG_W'(phase_thr[p]));
      for (int k = 0; k < 88; k++) begin
        if (p == 3 && k == 48) quiet = 1;
        if (p == 1 && k == 40) hold_req = 1;
        if (p == 0 && k == 45) begin
          det_ch.valid <= 1'b0;
          while (pending_reports.size() != 0) @(posedge clk);
        end
        sender_gap();
        send_det(random_det(), 0, 0);
      end
    end
    det_ch.valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d results never arrived", pending_reports.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
